[rtl/pat_pkg.sv]
package pat_pkg;

    // default field widths
    localparam int WAVELENGTH_BITS_DEFAULT = 20;
    localparam int COUNT_BITS_DEFAULT      = 16;

    // result widths
    localparam int AREA_BITS       = 39;
    localparam int BACKGROUND_BITS = 38;
    localparam int NET_BITS        = 40;

    // area saturates at +/- 2^AREA_LIMIT_BIT, background at +2^AREA_LIMIT_BIT
    localparam int AREA_LIMIT_BIT = 37;

    // entries between front and back
    localparam int QUEUE_DEPTH = 2;

    // register port
    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;

    typedef enum logic {
        REG_WINDOW_LOW  = 1'b0,
        REG_WINDOW_HIGH = 1'b1
    } pat_reg_t;

    // classification of one sample, made by the front
    typedef struct packed {
        logic in_window;
        logic last;
    } pat_flags_t;

endpackage

[rtl/peak_area_trapezoid.sv]
// trapezoidal peak area over an inclusive wavelength window, with a flat
// baseline of twice the span from first to last in-window wavelength times
// the first in-window count. samples stream in one transaction per clock
// while the queue has room; the sample marked final produces exactly one
// result transaction (area, background, net area, empty flag) and clears the
// spectrum state. a transaction is accepted every cycle while the result side
// keeps up; when a result is held on the output, the two-entry queue between
// the front and back keeps taking samples until it fills. an accepted sample
// passes the queue, multiply stage, accumulate stage and output register;
// the sustained rate of one sample per cycle is set by the single
// multiply-accumulate path in the back end. window_low (byte address 0) and
// window_high (byte address 4) must be written over the register port by the
// user only while no spectrum is in flight; the block does not enforce this.
module peak_area_trapezoid #(
    parameter int WAVELENGTH_BITS = pat_pkg::WAVELENGTH_BITS_DEFAULT,
    parameter int COUNT_BITS      = pat_pkg::COUNT_BITS_DEFAULT
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // register port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [pat_pkg::APB_ADDR_BITS-1:0]    paddr,
    input  logic [pat_pkg::APB_DATA_BITS-1:0]    pwdata,
    output logic [pat_pkg::APB_DATA_BITS-1:0]    prdata,
    output logic                                 pready,
    // sample channel
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [WAVELENGTH_BITS-1:0]           s_sample_wavelength,
    input  logic [COUNT_BITS-1:0]                s_sample_count,
    input  logic                                 s_final_sample,
    // result channel
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [pat_pkg::AREA_BITS-1:0] m_peak_area,
    output logic [pat_pkg::BACKGROUND_BITS-1:0]  m_background,
    output logic signed [pat_pkg::NET_BITS-1:0]  m_net_area,
    output logic                                 m_window_empty
);

    // queue entry: wavelength, count, classification flags
    localparam int FLAGS_W = $bits(pat_pkg::pat_flags_t);
    localparam int ENTRY_W = WAVELENGTH_BITS + COUNT_BITS + FLAGS_W;

    logic                       q_full;
    logic                       q_push;
    logic                       q_pop;
    logic                       q_not_empty;
    logic [WAVELENGTH_BITS-1:0] f_wavelength;
    logic [COUNT_BITS-1:0]      f_count;
    pat_pkg::pat_flags_t        f_flags;
    logic [ENTRY_W-1:0]         q_in;
    logic [ENTRY_W-1:0]         q_out;
    logic [WAVELENGTH_BITS-1:0] b_wavelength;
    logic [COUNT_BITS-1:0]      b_count;
    pat_pkg::pat_flags_t        b_flags;

    // front: register port, window test, push into queue
    pat_front #(
        .WAVELENGTH_BITS (WAVELENGTH_BITS),
        .COUNT_BITS      (COUNT_BITS)
    ) u_front (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_sample_wavelength (s_sample_wavelength),
        .s_sample_count      (s_sample_count),
        .s_final_sample      (s_final_sample),
        .q_full              (q_full),
        .q_push              (q_push),
        .q_wavelength        (f_wavelength),
        .q_count             (f_count),
        .q_flags             (f_flags)
    );

    assign q_in = {f_wavelength, f_count, f_flags};

    // decouples input acceptance from result backpressure
    pat_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (pat_pkg::QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .not_empty (q_not_empty)
    );

    assign {b_wavelength, b_count, b_flags} = q_out;

    // back: multiply, accumulate with saturation, output register
    pat_back #(
        .WAVELENGTH_BITS (WAVELENGTH_BITS),
        .COUNT_BITS      (COUNT_BITS)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (q_not_empty),
        .q_pop          (q_pop),
        .q_wavelength   (b_wavelength),
        .q_count        (b_count),
        .q_flags        (b_flags),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_peak_area    (m_peak_area),
        .m_background   (m_background),
        .m_net_area     (m_net_area),
        .m_window_empty (m_window_empty)
    );

    // an empty window reports all zero values
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_window_empty |->
            (m_peak_area == '0) && (m_background == '0) && (m_net_area == '0))
        else $error("empty window result carries nonzero values");

    // net area is always area minus background
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_net_area == (pat_pkg::NET_BITS'(m_peak_area) -
                                   pat_pkg::NET_BITS'($signed({1'b0, m_background}))))
        else $error("net area does not match area minus background");

    // background never exceeds its saturation limit
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_background <=
            pat_pkg::BACKGROUND_BITS'(64'd1 << pat_pkg::AREA_LIMIT_BIT))
        else $error("background above saturation limit");

    // queue is empty out of reset, so samples are taken at once
    assert property (@(posedge aclk)
        $past(!aresetn) && aresetn |-> s_ready && !m_valid)
        else $error("block not ready after reset");

endmodule

[rtl/pat_queue.sv]
module pat_queue #(
    parameter int WIDTH = 38,
    parameter int DEPTH = pat_pkg::QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             not_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[rtl/pat_front.sv]
module pat_front #(
    parameter int WAVELENGTH_BITS = pat_pkg::WAVELENGTH_BITS_DEFAULT,
    parameter int COUNT_BITS      = pat_pkg::COUNT_BITS_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // register port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pat_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  logic [pat_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic [pat_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                pready,
    // sample channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [WAVELENGTH_BITS-1:0]          s_sample_wavelength,
    input  logic [COUNT_BITS-1:0]               s_sample_count,
    input  logic                                s_final_sample,
    // queue side
    input  logic                                q_full,
    output logic                                q_push,
    output logic [WAVELENGTH_BITS-1:0]          q_wavelength,
    output logic [COUNT_BITS-1:0]               q_count,
    output pat_pkg::pat_flags_t                 q_flags
);

    logic [WAVELENGTH_BITS-1:0] window_low_reg;
    logic [WAVELENGTH_BITS-1:0] window_high_reg;
    pat_pkg::pat_reg_t          reg_sel;
    logic                       wr_en;

    assign pready  = 1'b1;
    assign reg_sel = pat_pkg::pat_reg_t'(paddr[2]);
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_low_reg  <= '0;
            window_high_reg <= '1;
        end else if (wr_en) begin
            case (reg_sel)
                pat_pkg::REG_WINDOW_LOW:  window_low_reg  <= pwdata[WAVELENGTH_BITS-1:0];
                pat_pkg::REG_WINDOW_HIGH: window_high_reg <= pwdata[WAVELENGTH_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            pat_pkg::REG_WINDOW_LOW:  prdata = pat_pkg::APB_DATA_BITS'(window_low_reg);
            pat_pkg::REG_WINDOW_HIGH: prdata = pat_pkg::APB_DATA_BITS'(window_high_reg);
            default:                  prdata = '0;
        endcase
    end

    // inclusive window test
    assign s_ready           = !q_full;
    assign q_push            = s_valid && !q_full;
    assign q_wavelength      = s_sample_wavelength;
    assign q_count           = s_sample_count;
    assign q_flags.in_window = (s_sample_wavelength >= window_low_reg) &&
                               (s_sample_wavelength <= window_high_reg);
    assign q_flags.last      = s_final_sample;

endmodule

[rtl/pat_back.sv]
module pat_back #(
    parameter int WAVELENGTH_BITS = pat_pkg::WAVELENGTH_BITS_DEFAULT,
    parameter int COUNT_BITS      = pat_pkg::COUNT_BITS_DEFAULT
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    // queue side
    input  logic                                       q_valid,
    output logic                                       q_pop,
    input  logic [WAVELENGTH_BITS-1:0]                 q_wavelength,
    input  logic [COUNT_BITS-1:0]                      q_count,
    input  pat_pkg::pat_flags_t                        q_flags,
    // result channel
    output logic                                       m_valid,
    input  logic                                       m_ready,
    output logic signed [pat_pkg::AREA_BITS-1:0]       m_peak_area,
    output logic [pat_pkg::BACKGROUND_BITS-1:0]        m_background,
    output logic signed [pat_pkg::NET_BITS-1:0]        m_net_area,
    output logic                                       m_window_empty
);

    localparam int W      = WAVELENGTH_BITS;
    localparam int C      = COUNT_BITS;
    localparam int AREA_W = pat_pkg::AREA_BITS;
    localparam int BGO_W  = pat_pkg::BACKGROUND_BITS;
    localparam int NET_W  = pat_pkg::NET_BITS;
    localparam int LIM    = pat_pkg::AREA_LIMIT_BIT;
    localparam int DW_W   = W + 1;
    localparam int CS_W   = C + 1;
    localparam int PROD_W = W + C + 2;
    localparam int BG_W   = W + C + 1;
    localparam int SUM_W  = ((PROD_W > AREA_W) ? PROD_W : AREA_W) + 1;
    localparam int BGX_W  = (BG_W > BGO_W + 1) ? BG_W : BGO_W + 1;

    localparam logic signed [SUM_W-1:0] AREA_MAX = SUM_W'(64'd1 << LIM);
    localparam logic signed [SUM_W-1:0] AREA_MIN = -AREA_MAX;
    localparam logic [BGX_W-1:0]        BG_MAX   = BGX_W'(64'd1 << LIM);

    logic advance;

    // stage 1 state: first and previous in-window sample
    logic                 have_first_reg, have_first_next;
    logic [W-1:0]         first_wl_reg, first_wl_next;
    logic [C-1:0]         first_cnt_reg, first_cnt_next;
    logic [W-1:0]         prev_wl_reg, prev_wl_next;
    logic [C-1:0]         prev_cnt_reg, prev_cnt_next;

    logic                 take;
    logic signed [DW_W-1:0]  dw;
    logic [CS_W-1:0]         cs;
    logic signed [PROD_W:0]  mul_full;
    logic signed [DW_W-1:0]  span_full;
    logic [W-1:0]            span_pos;
    logic [W+C-1:0]          bg_mul;

    logic                     s1_valid_reg;
    logic                     s1_add_reg;
    logic                     s1_last_reg;
    logic                     s1_empty_reg;
    logic signed [PROD_W-1:0] s1_prod_reg;
    logic [BG_W-1:0]          s1_bg_reg;

    // stage 2: accumulate
    logic signed [AREA_W-1:0] acc_reg;
    logic signed [SUM_W-1:0]  sum;
    logic signed [AREA_W-1:0] area_next;
    logic [BGX_W-1:0]         bg_ext;
    logic [BGO_W-1:0]         bg_sat;

    logic                     s2_valid_reg;
    logic signed [AREA_W-1:0] s2_area_reg;
    logic [BGO_W-1:0]         s2_bg_reg;
    logic                     s2_empty_reg;

    // stage 3: output register
    logic                     m_valid_reg;
    logic signed [AREA_W-1:0] m_area_reg;
    logic [BGO_W-1:0]         m_bg_reg;
    logic signed [NET_W-1:0]  m_net_reg, m_net_next;
    logic                     m_empty_reg;

    assign advance = !m_valid_reg || m_ready;
    assign q_pop   = q_valid && advance;
    assign take    = q_pop && q_flags.in_window;

    always_comb begin
        have_first_next = have_first_reg;
        first_wl_next   = first_wl_reg;
        first_cnt_next  = first_cnt_reg;
        prev_wl_next    = prev_wl_reg;
        prev_cnt_next   = prev_cnt_reg;
        if (take) begin
            if (!have_first_reg) begin
                have_first_next = 1'b1;
                first_wl_next   = q_wavelength;
                first_cnt_next  = q_count;
            end
            prev_wl_next  = q_wavelength;
            prev_cnt_next = q_count;
        end
    end

    assign dw        = $signed({1'b0, q_wavelength}) - $signed({1'b0, prev_wl_reg});
    assign cs        = {1'b0, q_count} + {1'b0, prev_cnt_reg};
    assign mul_full  = dw * $signed({1'b0, cs});
    assign span_full = $signed({1'b0, prev_wl_next}) - $signed({1'b0, first_wl_next});
    assign span_pos  = span_full[DW_W-1] ? '0 : span_full[W-1:0];
    assign bg_mul    = span_pos * first_cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_first_reg <= 1'b0;
            first_wl_reg   <= '0;
            first_cnt_reg  <= '0;
            prev_wl_reg    <= '0;
            prev_cnt_reg   <= '0;
            s1_valid_reg   <= 1'b0;
        end else if (advance) begin
            s1_valid_reg <= q_pop;
            if (q_pop && q_flags.last) begin
                // spectrum done, start over
                have_first_reg <= 1'b0;
                first_wl_reg   <= '0;
                first_cnt_reg  <= '0;
                prev_wl_reg    <= '0;
                prev_cnt_reg   <= '0;
            end else begin
                have_first_reg <= have_first_next;
                first_wl_reg   <= first_wl_next;
                first_cnt_reg  <= first_cnt_next;
                prev_wl_reg    <= prev_wl_next;
                prev_cnt_reg   <= prev_cnt_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s1_add_reg   <= take && have_first_reg;
            s1_last_reg  <= q_flags.last;
            s1_empty_reg <= !have_first_next;
            s1_prod_reg  <= mul_full[PROD_W-1:0];
            s1_bg_reg    <= {bg_mul, 1'b0};
        end
    end

    always_comb begin
        sum = SUM_W'(acc_reg) + (s1_add_reg ? SUM_W'(s1_prod_reg) : SUM_W'(0));
        if (sum > AREA_MAX) begin
            area_next = AREA_MAX[AREA_W-1:0];
        end else if (sum < AREA_MIN) begin
            area_next = AREA_MIN[AREA_W-1:0];
        end else begin
            area_next = sum[AREA_W-1:0];
        end
        bg_ext = BGX_W'(s1_bg_reg);
        bg_sat = (bg_ext > BG_MAX) ? BG_MAX[BGO_W-1:0] : bg_ext[BGO_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg      <= '0;
            s2_valid_reg <= 1'b0;
        end else if (advance) begin
            s2_valid_reg <= s1_valid_reg && s1_last_reg;
            if (s1_valid_reg) begin
                acc_reg <= s1_last_reg ? '0 : area_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s2_area_reg  <= area_next;
            s2_bg_reg    <= bg_sat;
            s2_empty_reg <= s1_empty_reg;
        end
    end

    assign m_net_next = NET_W'(s2_area_reg) - NET_W'($signed({1'b0, s2_bg_reg}));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_area_reg  <= s2_area_reg;
            m_bg_reg    <= s2_bg_reg;
            m_net_reg   <= m_net_next;
            m_empty_reg <= s2_empty_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_peak_area    = m_area_reg;
    assign m_background   = m_bg_reg;
    assign m_net_area     = m_net_reg;
    assign m_window_empty = m_empty_reg;

endmodule

[verif/pat_scoreboard_pkg.sv]
`timescale 1ns / 100ps

package pat_scoreboard_pkg;

    import pat_pkg::*;

    localparam int    WL_BITS    = WAVELENGTH_BITS_DEFAULT;
    localparam int    CNT_BITS   = COUNT_BITS_DEFAULT;
    localparam longint AREA_LIMIT = longint'(1) << AREA_LIMIT_BIT;

    typedef struct {
        logic [AREA_BITS-1:0]       area;
        logic [BACKGROUND_BITS-1:0] bg;
        logic [NET_BITS-1:0]        net;
        logic                       empty;
    } area_result_t;

    class area_scoreboard;

        // window registers, as last written
        bit [WL_BITS-1:0]  win_lo;
        bit [WL_BITS-1:0]  win_hi;

        // spectrum state
        bit                have_first;
        bit [WL_BITS-1:0]  first_wl;
        bit [WL_BITS-1:0]  prev_wl;
        bit [CNT_BITS-1:0] first_cnt;
        bit [CNT_BITS-1:0] prev_cnt;
        longint            acc;

        area_result_t      pending_areas[$];

        int errors;
        int samples;
        int effective;
        int results;
        int empties;
        int saturations;

        function new();
            win_lo = '0;
            win_hi = '1;
            clear_spectrum();
        endfunction

        function void clear_spectrum();
            have_first = 1'b0;
            first_wl   = '0;
            prev_wl    = '0;
            first_cnt  = '0;
            prev_cnt   = '0;
            acc        = 0;
        endfunction

        function void set_window(pat_reg_t r, bit [WL_BITS-1:0] v);
            if (r == REG_WINDOW_LOW) begin
                win_lo = v;
            end else begin
                win_hi = v;
            end
        endfunction

        function int pending();
            return pending_areas.size();
        endfunction

        // one accepted sample transaction
        function void take_sample(bit [WL_BITS-1:0] wl, bit [CNT_BITS-1:0] cnt, bit last);
            area_result_t r;
            longint       dw;
            longint       cs;
            longint       sum;
            longint       span;
            longint       bgv;
            bit           hit;
            hit = (wl >= win_lo) && (wl <= win_hi);
            samples++;
            if (hit || last) effective++;
            if (hit) begin
                if (have_first) begin
                    dw  = longint'(wl) - longint'(prev_wl);
                    cs  = longint'(cnt) + longint'(prev_cnt);
                    sum = acc + dw * cs;
                    if (sum > AREA_LIMIT) begin
                        sum = AREA_LIMIT;
                        saturations++;
                    end else if (sum < -AREA_LIMIT) begin
                        sum = -AREA_LIMIT;
                        saturations++;
                    end
                    acc = sum;
                end else begin
                    have_first = 1'b1;
                    first_wl   = wl;
                    first_cnt  = cnt;
                end
                prev_wl  = wl;
                prev_cnt = cnt;
            end
            if (!last) return;
            if (!have_first) begin
                r.area  = '0;
                r.bg    = '0;
                r.net   = '0;
                r.empty = 1'b1;
            end else begin
                span = longint'(prev_wl) - longint'(first_wl);
                if (span < 0) span = 0;
                bgv = 2 * span * longint'(first_cnt);
                if (bgv > AREA_LIMIT) bgv = AREA_LIMIT;
                r.area  = AREA_BITS'(acc);
                r.bg    = BACKGROUND_BITS'(bgv);
                r.net   = NET_BITS'(acc - bgv);
                r.empty = 1'b0;
            end
            pending_areas = {pending_areas, r};
            clear_spectrum();
        endfunction

        // one accepted result transaction
        function void check_result(logic [AREA_BITS-1:0] area, logic [BACKGROUND_BITS-1:0] bg,
                                   logic [NET_BITS-1:0] net, logic empty);
            area_result_t e;
            if (pending_areas.size() == 0) begin
                $error("result transaction with nothing pending");
                errors++;
                return;
            end
            e = pending_areas.pop_front();
            results++;
            if (e.empty) empties++;
            if (area !== e.area) begin
                $error("peak_area: expected %0d, got %0d", $signed(e.area), $signed(area));
                errors++;
            end
            if (bg !== e.bg) begin
                $error("background: expected %0d, got %0d", e.bg, bg);
                errors++;
            end
            if (net !== e.net) begin
                $error("net_area: expected %0d, got %0d", $signed(e.net), $signed(net));
                errors++;
            end
            if (empty !== e.empty) begin
                $error("window_empty: expected %0b, got %0b", e.empty, empty);
                errors++;
            end
        endfunction

    endclass

endpackage

[verif/tb_peak_area_trapezoid.sv]
`timescale 1ns / 100ps

module tb_peak_area_trapezoid;

    import pat_pkg::*;
    import pat_scoreboard_pkg::*;

    localparam bit [WL_BITS-1:0]  WL_MAX      = '1;
    localparam bit [CNT_BITS-1:0] CNT_MAX     = '1;
    localparam int                STALL_LIMIT = 2000;   // quiet cycles before giving up
    localparam int                RANDOM_ITEMS = 1400;
    localparam int                CALM_TAIL    = 200;   // items at the end with no idling
    localparam int                SETTLE      = 8;      // settling margin before register writes and at the end

    // every input starts at a known value
    logic                         aclk;
    logic                         aresetn             = 1'b0;
    logic                         psel                = 1'b0;
    logic                         penable             = 1'b0;
    logic                         pwrite              = 1'b0;
    logic [APB_ADDR_BITS-1:0]     paddr               = '0;
    logic [APB_DATA_BITS-1:0]     pwdata              = '0;
    logic [APB_DATA_BITS-1:0]     prdata;
    logic                         pready;
    logic                         s_valid             = 1'b0;
    logic                         s_ready;
    logic [WL_BITS-1:0]           s_sample_wavelength = '0;
    logic [CNT_BITS-1:0]          s_sample_count      = '0;
    logic                         s_final_sample      = 1'b0;
    logic                         m_valid;
    logic                         m_ready             = 1'b0;
    logic signed [AREA_BITS-1:0]  m_peak_area;
    logic [BACKGROUND_BITS-1:0]   m_background;
    logic signed [NET_BITS-1:0]   m_net_area;
    logic                         m_window_empty;

    area_scoreboard sb = new();

    // idling knobs, changed per phase
    bit idle_enable  = 1'b1;
    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    int sink_stall   = 0;
    int reg_errors   = 0;
    int reg_writes   = 0;

    peak_area_trapezoid i_dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_sample_wavelength (s_sample_wavelength),
        .s_sample_count      (s_sample_count),
        .s_final_sample      (s_final_sample),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_peak_area         (m_peak_area),
        .m_background        (m_background),
        .m_net_area          (m_net_area),
        .m_window_empty      (m_window_empty)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // result side backpressure: bursts of stalled cycles of random length
    always @(negedge aclk) begin
        if (sink_stall == 0 && idle_enable && $urandom_range(0, 99) < snk_idle_pct) begin
            sink_stall = $urandom_range(1, 10);
        end
        if (sink_stall > 0) begin
            m_ready <= 1'b0;
            sink_stall--;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // both channels are observed at the rising edge
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            sb.take_sample(s_sample_wavelength, s_sample_count, s_final_sample);
        end
        if (aresetn && m_valid && m_ready) begin
            sb.check_result(m_peak_area, m_background, m_net_area, m_window_empty);
        end
    end

    // ends the run when nothing moves for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        wait (aresetn === 1'b1);
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || psel) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    // one sample transaction, with an optional gap in front of it
    task automatic push_sample(input bit [WL_BITS-1:0] wl, input bit [CNT_BITS-1:0] cnt,
                               input bit last);
        int gap;
        gap = 0;
        if (idle_enable && $urandom_range(0, 99) < src_idle_pct) begin
            gap = $urandom_range(1, 10);
        end
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid             <= 1'b1;
        s_sample_wavelength <= wl;
        s_sample_count      <= cnt;
        s_final_sample      <= last;
        do @(posedge aclk); while (!s_ready);
    endtask

    // sender holds off until every pending result transaction has come back
    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    // register write followed by a read-back, setup and access phase each
    task automatic write_reg(input pat_reg_t r, input bit [WL_BITS-1:0] v);
        logic [APB_DATA_BITS-1:0] rd;
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= APB_DATA_BITS'(v);
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.set_window(r, v);
        reg_writes++;
        // straight into the read setup phase, psel stays high
        @(negedge aclk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rd = prdata;
        if (rd !== APB_DATA_BITS'(v)) begin
            $error("%s read-back: expected %0d, got %0d", r.name(), v, rd);
            reg_errors++;
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // window changes only once the block has gone quiet
    task automatic set_window(input bit [WL_BITS-1:0] lo, input bit [WL_BITS-1:0] hi);
        drain_results();
        repeat (SETTLE) @(posedge aclk);
        write_reg(REG_WINDOW_LOW, lo);
        write_reg(REG_WINDOW_HIGH, hi);
    endtask

    task automatic pick_window(output bit [WL_BITS-1:0] lo, output bit [WL_BITS-1:0] hi);
        longint l;
        longint h;
        case ($urandom_range(0, 9))
            0: begin l = 0; h = WL_MAX; end
            1: begin l = $urandom_range(0, WL_MAX); h = l; end
            2: begin h = $urandom_range(0, WL_MAX - 1); l = h + $urandom_range(1, 4096); end
            3: begin l = 0; h = $urandom_range(0, WL_MAX); end
            4: begin l = $urandom_range(0, WL_MAX); h = WL_MAX; end
            default: begin
                l = $urandom_range(0, WL_MAX);
                h = l + $urandom_range(0, 1 << $urandom_range(4, 19));
            end
        endcase
        if (l > WL_MAX) l = WL_MAX;
        if (h > WL_MAX) h = WL_MAX;
        lo = WL_BITS'(l);
        hi = WL_BITS'(h);
    endtask

    function automatic int pick_idle();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 5;
            2:       return 20;
            default: return 50;
        endcase
    endfunction

    // one spectrum shaped around the current window
    task automatic run_random_spectrum();
        longint lo_l;
        longint hi_l;
        longint w;
        longint margin;
        longint step;
        longint wl;
        int     len;
        int     shape;
        int     cmode;
        bit [CNT_BITS-1:0] cnt;
        lo_l = sb.win_lo;
        hi_l = sb.win_hi;
        if (hi_l < lo_l) begin
            // inverted window: sweep across the gap between the bounds
            w    = lo_l - hi_l + 64;
            lo_l = hi_l;
        end else begin
            w = hi_l - lo_l;
        end
        len    = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
        shape  = $urandom_range(0, 9);
        cmode  = $urandom_range(0, 3);
        margin = $urandom_range(0, 64) + w / 8;
        step   = (w + 2 * margin) / len;
        if (step < 1) step = 1;
        for (int i = 0; i < len; i++) begin
            case (shape)
                6:       wl = lo_l + w + margin - i * step;         // falling sweep
                7:       wl = $urandom_range(0, WL_MAX);           // noise
                8:       wl = lo_l + $urandom_range(0, int'(w));    // unordered, in window
                9:       wl = $urandom_range(0, 1) ? 0 : WL_MAX;   // full-scale jumps
                default: wl = lo_l - margin + i * step + $urandom_range(0, int'(step / 4));
            endcase
            if (wl < 0) wl = 0;
            if (wl > WL_MAX) wl = WL_MAX;
            case (cmode)
                1:       cnt = CNT_BITS'($urandom_range(0, 255));
                2:       cnt = $urandom_range(0, 1) ? CNT_MAX : '0;
                default: cnt = CNT_BITS'($urandom_range(0, CNT_MAX));
            endcase
            push_sample(WL_BITS'(wl), cnt, i == len - 1);
            // now and then the sender waits for the output to empty mid-stream
            if ($urandom_range(0, 299) == 0) drain_results();
        end
    endtask

    initial begin : stimulus
        bit [WL_BITS-1:0] lo;
        bit [WL_BITS-1:0] hi;
        int               rand_start;
        int               phase;

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed part, light idling on both sides
        src_idle_pct = 20;
        snk_idle_pct = 20;
        set_window('0, WL_MAX);
        // single sample that is also the final one
        push_sample('0, '0, 1'b1);
        // full-scale rising and falling spans, falling one has negative span
        push_sample('0, CNT_MAX, 1'b0);
        push_sample(WL_MAX, CNT_MAX, 1'b1);
        push_sample(WL_MAX, CNT_MAX, 1'b0);
        push_sample('0, CNT_MAX, 1'b1);
        // area driven past the positive limit
        push_sample('0, CNT_MAX, 1'b0);
        push_sample(WL_MAX, CNT_MAX, 1'b0);
        push_sample(WL_MAX, '0, 1'b0);
        push_sample('0, '0, 1'b0);
        push_sample(WL_MAX, CNT_MAX, 1'b1);
        // and past the negative limit
        push_sample(WL_MAX, CNT_MAX, 1'b0);
        push_sample('0, CNT_MAX, 1'b0);
        push_sample('0, '0, 1'b0);
        push_sample(WL_MAX, '0, 1'b0);
        push_sample('0, CNT_MAX, 1'b1);

        set_window(20'd1000, 20'd2000);
        // just outside both bounds: empty window
        push_sample(20'd999, 16'd5, 1'b0);
        push_sample(20'd2001, 16'd6, 1'b1);
        // both bounds hit, final sample outside the window
        push_sample(20'd1000, 16'd10, 1'b0);
        push_sample(20'd1500, 16'd20, 1'b0);
        push_sample(20'd2000, 16'd30, 1'b0);
        push_sample(20'd3000, 16'd5, 1'b1);
        // falling wavelengths inside the window
        push_sample(20'd1500, 16'd7, 1'b0);
        push_sample(20'd1200, 16'd9, 1'b1);

        // inverted window never matches
        set_window(20'd5000, 20'd4000);
        push_sample(20'd4500, 16'd1, 1'b1);

        // one-point window at the top of the range
        set_window(WL_MAX, WL_MAX);
        push_sample(WL_MAX, CNT_MAX, 1'b1);
        push_sample(WL_MAX - 1'b1, 16'd3, 1'b1);

        // random part: phases of spectra under one window and idling mix each
        rand_start = sb.samples;
        phase      = 0;
        while (sb.samples - rand_start < RANDOM_ITEMS) begin
            if (phase == 0) begin
                lo = '0;
                hi = WL_MAX;
            end else begin
                pick_window(lo, hi);
            end
            set_window(lo, hi);
            src_idle_pct = pick_idle();
            snk_idle_pct = pick_idle();
            repeat ($urandom_range(3, 12)) begin
                if (sb.samples - rand_start < RANDOM_ITEMS) begin
                    if (sb.samples - rand_start >= RANDOM_ITEMS - CALM_TAIL) begin
                        // closing stretch runs flat out
                        idle_enable = 1'b0;
                    end
                    run_random_spectrum();
                end
            end
            phase++;
        end

        // wait for the last results, then a few more cycles for strays
        drain_results();
        repeat (4 * SETTLE) @(posedge aclk);

        $display("ran %0d samples (%0d in window or final) over %0d window settings",
                 sb.samples, sb.effective, reg_writes / 2);
        $display("checked %0d results: %0d empty windows, %0d saturating area steps",
                 sb.results, sb.empties, sb.saturations);
        if (sb.errors == 0 && reg_errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/pat_pkg.sv
rtl/pat_queue.sv
rtl/pat_front.sv
rtl/pat_back.sv
rtl/peak_area_trapezoid.sv
verif/pat_scoreboard_pkg.sv
verif/tb_peak_area_trapezoid.sv
